@@ src/sdacq_pkg.sv @@
// sdacq_pkg: types, codes and constants of the sd card acquisition sequencer
// no dependencies; imported by sd_card_acquisition_sequencer
`timescale 1ns / 1ps
`default_nettype none

package sdacq_pkg;

   // field widths
   localparam int unsigned OCR_W      = 24;
   localparam int unsigned RCA_W      = 16;
   localparam int unsigned ERR_W      = 2;
   localparam int unsigned ECHO_W     = 8;
   localparam int unsigned IDX_W      = 6;
   localparam int unsigned ARG_W      = 32;
   localparam int unsigned KIND_W     = 3;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 24;
   localparam int unsigned REQ_DATA_W = 32;
   localparam int unsigned RSP_DATA_W = 64;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HOST_OCR = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MMC_RCA  = 1'd1;

   // configuration reset values
   localparam logic [OCR_W-1:0] HOST_OCR_RESET = 24'hFF8000;
   localparam logic [RCA_W-1:0] MMC_RCA_RESET  = 16'd1;

   // protocol constants
   localparam logic [OCR_W-1:0]  OCR_VOLT_MASK = 24'hFF8000;
   localparam logic [ECHO_W-1:0] CHECK_PATTERN = 8'hAA;
   localparam logic [ARG_W-1:0]  CMD8_VHS_ARG  = 32'h0000_0100;
   localparam logic [ARG_W-1:0]  ACMD41_ARG    = 32'h00FF_8000;
   localparam int unsigned       HCS_BIT       = 30;
   localparam int unsigned       RCA_SHIFT     = 16;

   // command numbers
   localparam logic [IDX_W-1:0] CMD_GO_IDLE    = 6'd0;
   localparam logic [IDX_W-1:0] CMD_SEND_OP    = 6'd1;
   localparam logic [IDX_W-1:0] CMD_ALL_CID    = 6'd2;
   localparam logic [IDX_W-1:0] CMD_SET_RCA    = 6'd3;
   localparam logic [IDX_W-1:0] CMD_IF_COND    = 6'd8;
   localparam logic [IDX_W-1:0] CMD_SEND_CSD   = 6'd9;
   localparam logic [IDX_W-1:0] CMD_SD_SEND_OP = 6'd41;
   localparam logic [IDX_W-1:0] CMD_APP_CMD    = 6'd55;

   typedef enum logic [3:0] {
      PH_IDLE   = 4'd0,
      PH_RESET  = 4'd1,
      PH_CMD0   = 4'd2,
      PH_CMD8   = 4'd3,
      PH_CMD55  = 4'd4,
      PH_ACMD41 = 4'd5,
      PH_CMD1   = 4'd6,
      PH_CMD2   = 4'd7,
      PH_CMD3   = 4'd8,
      PH_CMD9   = 4'd9
   } phase_type;

   typedef enum logic [1:0] {
      ACT_SEND    = 2'd0,
      ACT_RESET   = 2'd1,
      ACT_DONE    = 2'd2,
      ACT_ABANDON = 2'd3
   } action_type;

   typedef enum logic [KIND_W-1:0] {
      RK_NONE = 3'd0,
      RK_R1   = 3'd1,
      RK_CID  = 3'd2,
      RK_CSD  = 3'd3,
      RK_R3   = 3'd4,
      RK_R6   = 3'd5
   } resp_kind_type;

   typedef enum logic {
      REQ_START    = 1'b0,
      REQ_COMPLETE = 1'b1
   } req_kind_type;

   localparam logic [ERR_W-1:0] ERR_OK = 2'd0;

endpackage

`default_nettype wire

@@ src/sd_card_acquisition_sequencer.sv @@
// sd_card_acquisition_sequencer: host-side sd/mmc card identification sequencer
// depends on sdacq_pkg
`timescale 1ns / 1ps
`default_nettype none

// The sequencer walks a card through identification one step per transfer.
// A start transfer (req_tuser 0) clears the held card state and answers with
// a host reset. Every completion transfer (req_tuser 1) carries the decoded
// verdict of the command last issued; the answer is the next command to send
// (CMD0, CMD8, CMD55/ACMD41 polling, CMD1 polling for MMC, CMD2, CMD3, CMD9)
// with its argument and expected response kind, or a final done / abandoned.
// Each answer also reports the held card type and relative card address.
// Throughput is one transfer per clock while rsp_tready is high; a transfer
// passes the input register, a single step of logic and the result register.
// The result register holds an answer while rsp_tready is low and the input
// register keeps accepting as long as the result register can drain.
// Configuration (csr_*) must only be written while no answer is pending; a
// write takes effect on the next command built.
module sd_card_acquisition_sequencer
   import sdacq_pkg::*;
(
   input  wire                     clock,
   input  wire                     reset,
   // configuration write port
   input  wire                     csr_we,
   input  wire [CSR_IDX_W-1:0]     csr_index,
   input  wire [CSR_DATA_W-1:0]    csr_wdata,
   // request channel
   input  wire                     req_tvalid,
   output logic                    req_tready,
   // tdata: resp_error[1:0], card_present[2], ocr_ready[3], check_echo[11:4],
   //        sd_published_rca[27:12], zero fill[31:28]
   input  wire [REQ_DATA_W-1:0]    req_tdata,
   // tuser: req_type[0]
   input  wire                     req_tuser,
   // response channel
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   // tdata: cmd_index[5:0], cmd_arg[37:6], resp_kind[40:38], card_is_sd[41],
   //        card_high_capacity[42], card_rca[58:43], zero fill[63:59]
   output logic [RSP_DATA_W-1:0]   rsp_tdata,
   // tuser: action[1:0]
   output logic [1:0]              rsp_tuser
);

   // configuration registers
   logic [OCR_W-1:0] host_ocr_ff;
   logic [RCA_W-1:0] mmc_rca_ff;

   // input register
   logic              stg_valid_ff;
   logic              stg_type_ff;
   logic [ERR_W-1:0]  stg_err_ff;
   logic              stg_present_ff;
   logic              stg_ready_ff;
   logic [ECHO_W-1:0] stg_echo_ff;
   logic [RCA_W-1:0]  stg_rca_ff;

   // sequencer state
   phase_type        phase_ff, phase_in;
   logic             is_sd_ff, is_sd_in;
   logic             is_v2_ff, is_v2_in;
   logic [RCA_W-1:0] held_rca_ff, held_rca_in;

   // result register
   logic              rsp_valid_ff;
   action_type        rsp_action_ff, action_in;
   logic [IDX_W-1:0]  rsp_index_ff, index_in;
   logic [ARG_W-1:0]  rsp_arg_ff, arg_in;
   resp_kind_type     rsp_kind_ff, kind_in;
   logic              rsp_is_sd_ff;
   logic              rsp_is_v2_ff;
   logic [RCA_W-1:0]  rsp_rca_ff;

   logic step_fire;
   logic req_fire;
   logic hard_err;

   // the step runs when the result register is empty or being drained
   assign step_fire  = stg_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !stg_valid_ff || step_fire;
   assign req_fire   = req_tvalid && req_tready;
   // verdicts 2 and 3 both count as a hard failure
   assign hard_err   = stg_err_ff[1];

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         host_ocr_ff <= HOST_OCR_RESET;
         mmc_rca_ff  <= MMC_RCA_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HOST_OCR: host_ocr_ff <= csr_wdata[OCR_W-1:0];
            CSR_MMC_RCA:  mmc_rca_ff  <= csr_wdata[RCA_W-1:0];
            default:      ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else if (req_tready) begin
         stg_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         stg_type_ff    <= req_tuser;
         stg_err_ff     <= req_tdata[1:0];
         stg_present_ff <= req_tdata[2];
         stg_ready_ff   <= req_tdata[3];
         stg_echo_ff    <= req_tdata[11:4];
         stg_rca_ff     <= req_tdata[27:12];
      end
   end

   // next command selection
   always_comb begin
      phase_in    = phase_ff;
      is_sd_in    = is_sd_ff;
      is_v2_in    = is_v2_ff;
      held_rca_in = held_rca_ff;
      action_in   = ACT_ABANDON;
      index_in    = '0;
      arg_in      = '0;
      kind_in     = RK_NONE;

      if (stg_type_ff == REQ_START) begin
         // restart from any phase
         is_sd_in    = 1'b0;
         is_v2_in    = 1'b0;
         held_rca_in = '0;
         phase_in    = PH_RESET;
         action_in   = ACT_RESET;
      end else begin
         case (phase_ff)
            PH_RESET: begin
               if (!stg_present_ff) begin
                  phase_in = PH_IDLE;            // empty slot
               end else begin
                  is_sd_in  = 1'b1;
                  phase_in  = PH_CMD0;
                  action_in = ACT_SEND;
                  index_in  = CMD_GO_IDLE;
               end
            end
            PH_CMD0: begin
               action_in = ACT_SEND;
               if (is_sd_ff) begin
                  phase_in = PH_CMD8;
                  index_in = CMD_IF_COND;
                  arg_in   = {{(ARG_W-ECHO_W){1'b0}}, CHECK_PATTERN}
                           | (((host_ocr_ff & OCR_VOLT_MASK) != '0) ? CMD8_VHS_ARG : '0);
                  kind_in  = RK_R6;
               end else begin
                  phase_in = PH_CMD1;
                  index_in = CMD_SEND_OP;
                  arg_in   = {{(ARG_W-OCR_W){1'b0}}, host_ocr_ff};
                  kind_in  = RK_R3;
               end
            end
            PH_CMD8: begin
               // echo must match and the answer must not have hard-failed
               is_v2_in  = (stg_echo_ff == CHECK_PATTERN) && !hard_err;
               phase_in  = PH_CMD55;
               action_in = ACT_SEND;
               index_in  = CMD_APP_CMD;
               kind_in   = RK_R1;
            end
            PH_CMD55: begin
               action_in = ACT_SEND;
               if (stg_err_ff != ERR_OK) begin
                  // no app command support: treat as mmc and start over
                  is_sd_in = 1'b0;
                  phase_in = PH_CMD0;
                  index_in = CMD_GO_IDLE;
               end else begin
                  phase_in = PH_ACMD41;
                  index_in = CMD_SD_SEND_OP;
                  arg_in   = ACMD41_ARG | ({{(ARG_W-1){1'b0}}, is_v2_ff} << HCS_BIT);
                  kind_in  = RK_R3;
               end
            end
            PH_ACMD41: begin
               action_in = ACT_SEND;
               if (stg_err_ff != ERR_OK) begin
                  phase_in = PH_CMD1;
                  index_in = CMD_SEND_OP;
                  arg_in   = {{(ARG_W-OCR_W){1'b0}}, host_ocr_ff};
                  kind_in  = RK_R3;
               end else if (!stg_ready_ff) begin
                  phase_in = PH_CMD55;          // card still powering up
                  index_in = CMD_APP_CMD;
                  kind_in  = RK_R1;
               end else begin
                  is_sd_in = 1'b1;
                  phase_in = PH_CMD2;
                  index_in = CMD_ALL_CID;
                  kind_in  = RK_CID;
               end
            end
            PH_CMD1: begin
               if (stg_err_ff != ERR_OK) begin
                  phase_in = PH_IDLE;
               end else if (!stg_ready_ff) begin
                  phase_in  = PH_CMD1;
                  action_in = ACT_SEND;
                  index_in  = CMD_SEND_OP;
                  arg_in    = {{(ARG_W-OCR_W){1'b0}}, host_ocr_ff};
                  kind_in   = RK_R3;
               end else begin
                  is_sd_in  = 1'b0;
                  phase_in  = PH_CMD2;
                  action_in = ACT_SEND;
                  index_in  = CMD_ALL_CID;
                  kind_in   = RK_CID;
               end
            end
            PH_CMD2: begin
               // crc-only errors tolerated on the cid
               if (hard_err) begin
                  phase_in = PH_IDLE;
               end else begin
                  phase_in  = PH_CMD3;
                  action_in = ACT_SEND;
                  index_in  = CMD_SET_RCA;
                  if (is_sd_ff) begin
                     kind_in = RK_R6;
                  end else begin
                     arg_in  = {{(ARG_W-RCA_W){1'b0}}, mmc_rca_ff} << RCA_SHIFT;
                     kind_in = RK_R1;
                  end
               end
            end
            PH_CMD3: begin
               // sd rca is taken even if the answer failed
               held_rca_in = is_sd_ff ? stg_rca_ff : mmc_rca_ff;
               if (stg_err_ff != ERR_OK) begin
                  phase_in = PH_IDLE;
               end else begin
                  phase_in  = PH_CMD9;
                  action_in = ACT_SEND;
                  index_in  = CMD_SEND_CSD;
                  arg_in    = {{(ARG_W-RCA_W){1'b0}}, held_rca_in} << RCA_SHIFT;
                  kind_in   = RK_CSD;
               end
            end
            PH_CMD9: begin
               phase_in  = PH_IDLE;
               action_in = hard_err ? ACT_ABANDON : ACT_DONE;
            end
            default: begin
               // completion with nothing outstanding
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         is_sd_ff    <= 1'b0;
         is_v2_ff    <= 1'b0;
         held_rca_ff <= '0;
      end else if (step_fire) begin
         phase_ff    <= phase_in;
         is_sd_ff    <= is_sd_in;
         is_v2_ff    <= is_v2_in;
         held_rca_ff <= held_rca_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_fire) begin
         rsp_action_ff <= action_in;
         rsp_index_ff  <= index_in;
         rsp_arg_ff    <= arg_in;
         rsp_kind_ff   <= kind_in;
         rsp_is_sd_ff  <= is_sd_in;
         rsp_is_v2_ff  <= is_v2_in;
         rsp_rca_ff    <= held_rca_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_action_ff;
   assign rsp_tdata  = {5'd0, rsp_rca_ff, rsp_is_v2_ff, rsp_is_sd_ff, rsp_kind_ff,
                        rsp_arg_ff, rsp_index_ff};

`ifndef SYNTHESIS
   // a final answer always leaves the sequencer idle
   assert property (@(posedge clock) disable iff (reset)
      step_fire && stg_type_ff == REQ_COMPLETE && action_in != ACT_SEND
      |=> phase_ff == PH_IDLE)
      else $error("sequencer not idle after final answer");

   // a start clears the held card state and waits for the host reset
   assert property (@(posedge clock) disable iff (reset)
      step_fire && stg_type_ff == REQ_START
      |=> phase_ff == PH_RESET && !is_sd_ff && !is_v2_ff && held_rca_ff == '0)
      else $error("start did not restart the sequence");

   // a waiting item is not replaced while the result register is blocked
   assert property (@(posedge clock) disable iff (reset)
      stg_valid_ff && rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("input register overrun");

   // answers other than send carry no command
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_action_ff != ACT_SEND
      |-> rsp_index_ff == '0 && rsp_arg_ff == '0 && rsp_kind_ff == RK_NONE)
      else $error("command fields set on a non-send answer");

   // reported state matches the sequencer state right after an answer is loaded
   assert property (@(posedge clock) disable iff (reset)
      step_fire |=> rsp_rca_ff == held_rca_ff && rsp_is_sd_ff == is_sd_ff)
      else $error("reported card state out of step");
`endif

endmodule

`default_nettype wire

@@ dv/sd_card_acquisition_sequencer_test.sv @@
// self-checking testbench for sd_card_acquisition_sequencer: directed table, then
// random card conversations checked against a behavioural copy of the sequencer
// depends on sdacq_pkg and the sequencer rtl
`timescale 1ns / 1ps

module sd_card_acquisition_sequencer_test;
   import sdacq_pkg::*;

   // verdict codes carried in resp_error
   localparam logic [ERR_W-1:0] ERR_CRC  = 2'd1;
   localparam logic [ERR_W-1:0] ERR_HARD = 2'd2;
   localparam logic [ERR_W-1:0] ERR_ANY  = 2'd3;

   // quiet cycles allowed with no transfer on either channel
   localparam int STALL_LIMIT   = 2000;
   // cycles left between the last answer and a register write
   localparam int SETTLE_CYCLES = 4;
   localparam int RANDOM_ITEMS  = 160;
   localparam int MAX_PRINTED   = 40;

   // one request: verdict of the last command, or a start
   typedef struct packed {
      logic               kind;
      logic [ERR_W-1:0]   err;
      logic               present;
      logic               ready;
      logic [ECHO_W-1:0]  echo;
      logic [RCA_W-1:0]   pub_rca;
   } acq_item_type;

   // one answer: next step plus the held card state
   typedef struct packed {
      logic [1:0]         action;
      logic [IDX_W-1:0]   idx;
      logic [ARG_W-1:0]   arg;
      logic [KIND_W-1:0]  rk;
      logic               is_sd;
      logic               hc;
      logic [RCA_W-1:0]   rca;
   } acq_step_type;

   // row of the directed table, with the answer typed in where it is obvious
   typedef struct packed {
      acq_item_type stim;
      logic         typed;
      acq_step_type want;
   } dir_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   // tdata: resp_error, card_present, ocr_ready, check_echo, sd_published_rca
   logic [REQ_DATA_W-1:0] req_tdata;
   // tuser: req_type
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // tdata: cmd_index, cmd_arg, resp_kind, card_is_sd, card_high_capacity, card_rca
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // tuser: action
   logic [1:0]            rsp_tuser;

   sd_card_acquisition_sequencer uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // behavioural copy of the sequencer state and its registers
   phase_type        seq_phase;
   logic             card_sd;
   logic             card_v2;
   logic [RCA_W-1:0] card_addr;
   logic [OCR_W-1:0] cfg_host_ocr;
   logic [RCA_W-1:0] cfg_mmc_rca;

   acq_step_type pending_answers[$];
   dir_row_type  directed_rows[$];

   int req_idle_pct;
   int rsp_idle_pct;
   int fail_count;
   int quiet_cycles;

   // ------------------------------------------------------------------
   // sequencer behaviour
   // ------------------------------------------------------------------

   function automatic acq_step_type command(input logic [IDX_W-1:0] idx,
                                            input logic [ARG_W-1:0] arg,
                                            input logic [KIND_W-1:0] rk);
      acq_step_type s;
      s        = '0;
      s.action = ACT_SEND;
      s.idx    = idx;
      s.arg    = arg;
      s.rk     = rk;
      return s;
   endfunction

   // works out the answer to one request and moves the held state on
   function automatic acq_step_type advance_sequencer(input acq_item_type it);
      acq_step_type s;
      logic      hard;
      logic      failed;
      hard     = (it.err >= ERR_HARD);
      failed   = (it.err != ERR_OK);
      s        = '0;
      s.action = ACT_ABANDON;
      s.rk     = RK_NONE;
      if (it.kind == REQ_START) begin
         // restart from any phase
         card_sd   = 1'b0;
         card_v2   = 1'b0;
         card_addr = '0;
         seq_phase = PH_RESET;
         s.action  = ACT_RESET;
      end else begin
         case (seq_phase)
            PH_RESET: begin
               // verdict ignored here, only the slot matters
               if (!it.present) begin
                  seq_phase = PH_IDLE;
               end else begin
                  card_sd   = 1'b1;
                  s         = command(CMD_GO_IDLE, '0, RK_NONE);
                  seq_phase = PH_CMD0;
               end
            end
            PH_CMD0: begin
               if (card_sd) begin
                  s = command(CMD_IF_COND,
                              (((cfg_host_ocr & OCR_VOLT_MASK) != '0) ? CMD8_VHS_ARG : '0)
                              | {24'd0, CHECK_PATTERN}, RK_R6);
                  seq_phase = PH_CMD8;
               end else begin
                  s         = command(CMD_SEND_OP, {8'd0, cfg_host_ocr}, RK_R3);
                  seq_phase = PH_CMD1;
               end
            end
            PH_CMD8: begin
               // echo must match and the verdict must not be a hard error
               card_v2   = (it.echo == CHECK_PATTERN) && !hard;
               s         = command(CMD_APP_CMD, '0, RK_R1);
               seq_phase = PH_CMD55;
            end
            PH_CMD55: begin
               if (failed) begin
                  // no app command support, treat as mmc
                  card_sd   = 1'b0;
                  s         = command(CMD_GO_IDLE, '0, RK_NONE);
                  seq_phase = PH_CMD0;
               end else begin
                  s = command(CMD_SD_SEND_OP,
                              ACMD41_ARG | ({31'd0, card_v2} << HCS_BIT), RK_R3);
                  seq_phase = PH_ACMD41;
               end
            end
            PH_ACMD41: begin
               if (failed) begin
                  s         = command(CMD_SEND_OP, {8'd0, cfg_host_ocr}, RK_R3);
                  seq_phase = PH_CMD1;
               end else if (!it.ready) begin
                  s         = command(CMD_APP_CMD, '0, RK_R1);
                  seq_phase = PH_CMD55;
               end else begin
                  card_sd   = 1'b1;
                  s         = command(CMD_ALL_CID, '0, RK_CID);
                  seq_phase = PH_CMD2;
               end
            end
            PH_CMD1: begin
               if (failed) begin
                  seq_phase = PH_IDLE;
               end else if (!it.ready) begin
                  s         = command(CMD_SEND_OP, {8'd0, cfg_host_ocr}, RK_R3);
                  seq_phase = PH_CMD1;
               end else begin
                  card_sd   = 1'b0;
                  s         = command(CMD_ALL_CID, '0, RK_CID);
                  seq_phase = PH_CMD2;
               end
            end
            PH_CMD2: begin
               // crc errors tolerated on the cid
               if (hard) begin
                  seq_phase = PH_IDLE;
               end else if (card_sd) begin
                  s         = command(CMD_SET_RCA, '0, RK_R6);
                  seq_phase = PH_CMD3;
               end else begin
                  s = command(CMD_SET_RCA, {16'd0, cfg_mmc_rca} << RCA_SHIFT, RK_R1);
                  seq_phase = PH_CMD3;
               end
            end
            PH_CMD3: begin
               // address is taken even when the command failed
               card_addr = card_sd ? it.pub_rca : cfg_mmc_rca;
               if (failed) begin
                  seq_phase = PH_IDLE;
               end else begin
                  s = command(CMD_SEND_CSD, {16'd0, card_addr} << RCA_SHIFT, RK_CSD);
                  seq_phase = PH_CMD9;
               end
            end
            PH_CMD9: begin
               s.action  = hard ? ACT_ABANDON : ACT_DONE;
               seq_phase = PH_IDLE;
            end
            default: begin
               // completion with nothing outstanding
               seq_phase = PH_IDLE;
            end
         endcase
      end
      s.is_sd = card_sd;
      s.hc    = card_v2;
      s.rca   = card_addr;
      return s;
   endfunction

   // random request, mostly a plausible answer to the command now outstanding
   function automatic acq_item_type next_random_item();
      acq_item_type it;
      int unsigned pick;
      it.kind = REQ_COMPLETE;
      if (seq_phase == PH_IDLE) begin
         if ($urandom_range(99) < 85) it.kind = REQ_START;
      end else if ($urandom_range(99) < 2) begin
         it.kind = REQ_START;
      end
      pick = $urandom_range(99);
      if (pick < 82)      it.err = ERR_OK;
      else if (pick < 88) it.err = ERR_CRC;
      else if (pick < 94) it.err = ERR_HARD;
      else                it.err = ERR_ANY;
      it.present = ($urandom_range(99) < 93);
      it.ready   = ($urandom_range(99) < 45);
      it.echo    = ($urandom_range(99) < 70) ? CHECK_PATTERN : ECHO_W'($urandom);
      it.pub_rca = RCA_W'($urandom);
      return it;
   endfunction

   // ------------------------------------------------------------------
   // directed table building
   // ------------------------------------------------------------------

   task automatic stim_row(input logic kind, input logic [ERR_W-1:0] err,
                           input logic present, input logic ready,
                           input logic [ECHO_W-1:0] echo, input logic [RCA_W-1:0] pub_rca);
      dir_row_type row;
      row              = '0;
      row.stim.kind    = kind;
      row.stim.err     = err;
      row.stim.present = present;
      row.stim.ready   = ready;
      row.stim.echo    = echo;
      row.stim.pub_rca = pub_rca;
      directed_rows.push_back(row);
   endtask

   // types the expected answer into the row just added
   task automatic want_last(input logic [1:0] action, input logic [IDX_W-1:0] idx,
                            input logic [ARG_W-1:0] arg, input logic [KIND_W-1:0] rk,
                            input logic is_sd, input logic hc, input logic [RCA_W-1:0] rca);
      dir_row_type row;
      row             = directed_rows.pop_back();
      row.typed       = 1'b1;
      row.want.action = action;
      row.want.idx    = idx;
      row.want.arg    = arg;
      row.want.rk     = rk;
      row.want.is_sd  = is_sd;
      row.want.hc     = hc;
      row.want.rca    = rca;
      directed_rows.push_back(row);
   endtask

   // ------------------------------------------------------------------
   // request side driving, called and returning at a falling edge
   // ------------------------------------------------------------------

   task automatic send_item(input acq_item_type it, input logic typed,
                            input acq_step_type want);
      acq_step_type predicted;
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = it.kind;
      req_tdata  = {4'd0, it.pub_rca, it.echo, it.ready, it.present, it.err};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // transfer taken: the model moves on even where the answer is typed in
      predicted = advance_sequencer(it);
      pending_answers.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   // register write once every answer is in and the pipeline has settled
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      req_tvalid = 1'b0;
      while (pending_answers.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      if (idx == CSR_HOST_OCR) cfg_host_ocr = value[OCR_W-1:0];
      else                     cfg_mmc_rca  = value[RCA_W-1:0];
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------

   task automatic report_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_PRINTED) $display("ERROR at %0t: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [ARG_W-1:0] got,
                              input logic [ARG_W-1:0] want);
      if (got !== want) report_failure($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   // answers are compared in order against the oldest expectation
   always @(posedge clock) begin : answer_check
      acq_step_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_answers.size() == 0) begin
            report_failure($sformatf("answer transfer with none expected, tuser %0h tdata %0h",
                                     rsp_tuser, rsp_tdata));
         end else begin
            want = pending_answers.pop_front();
            check_field("action", {30'd0, rsp_tuser}, {30'd0, want.action});
            check_field("cmd_index", {26'd0, rsp_tdata[5:0]}, {26'd0, want.idx});
            check_field("cmd_arg", rsp_tdata[37:6], want.arg);
            check_field("resp_kind", {29'd0, rsp_tdata[40:38]}, {29'd0, want.rk});
            check_field("card_is_sd", {31'd0, rsp_tdata[41]}, {31'd0, want.is_sd});
            check_field("card_high_capacity", {31'd0, rsp_tdata[42]}, {31'd0, want.hc});
            check_field("card_rca", {16'd0, rsp_tdata[58:43]}, {16'd0, want.rca});
         end
      end
   end

   // count quiet cycles; any transfer restarts the count
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= STALL_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // clock and answer side back-pressure
   // ------------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready = ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------

   initial begin : main_sequence
      dir_row_type      row;
      acq_step_type     unused;
      logic [OCR_W-1:0] ocr_value;
      logic [23:0]      rca_value;
      int               setting;

      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_index    = CSR_HOST_OCR;
      csr_wdata    = '0;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = REQ_START;
      req_idle_pct = 9;
      rsp_idle_pct = 71;
      fail_count   = 0;
      unused       = '0;

      // model state after reset
      seq_phase    = PH_IDLE;
      card_sd      = 1'b0;
      card_v2      = 1'b0;
      card_addr    = '0;
      cfg_host_ocr = HOST_OCR_RESET;
      cfg_mmc_rca  = MMC_RCA_RESET;

      // completion while idle, then an empty slot
      stim_row(REQ_COMPLETE, ERR_OK, 1'b1, 1'b1, 8'hFF, 16'hFFFF);
      want_last(ACT_ABANDON, '0, '0, RK_NONE, 1'b0, 1'b0, '0);
      stim_row(REQ_START, ERR_ANY, 1'b1, 1'b1, 8'hFF, 16'hFFFF);
      want_last(ACT_RESET, '0, '0, RK_NONE, 1'b0, 1'b0, '0);
      stim_row(REQ_COMPLETE, ERR_OK, 1'b0, 1'b0, 8'h00, 16'h0000);
      want_last(ACT_ABANDON, '0, '0, RK_NONE, 1'b0, 1'b0, '0);
      // sd card, v2, verdicts on reset and cmd0 ignored
      stim_row(REQ_START, ERR_OK, 1'b0, 1'b0, 8'h00, 16'h0000);
      want_last(ACT_RESET, '0, '0, RK_NONE, 1'b0, 1'b0, '0);
      stim_row(REQ_COMPLETE, ERR_ANY, 1'b1, 1'b0, 8'h00, 16'h0000);
      want_last(ACT_SEND, CMD_GO_IDLE, '0, RK_NONE, 1'b1, 1'b0, '0);
      stim_row(REQ_COMPLETE, ERR_HARD, 1'b1, 1'b0, 8'h00, 16'h0000);
      want_last(ACT_SEND, CMD_IF_COND, CMD8_VHS_ARG | {24'd0, CHECK_PATTERN}, RK_R6,
                1'b1, 1'b0, '0);
      // crc error on cmd8 still counts as a matching echo
      stim_row(REQ_COMPLETE, ERR_CRC, 1'b1, 1'b0, CHECK_PATTERN, 16'h0000);
      want_last(ACT_SEND, CMD_APP_CMD, '0, RK_R1, 1'b1, 1'b1, '0);
      stim_row(REQ_COMPLETE, ERR_OK, 1'b1, 1'b0, 8'h00, 16'h0000);
      want_last(ACT_SEND, CMD_SD_SEND_OP, ACMD41_ARG | (32'd1 << HCS_BIT), RK_R3,
                1'b1, 1'b1, '0);
      // busy once, then ready
      stim_row(REQ_COMPLETE, ERR_OK, 1'b1, 1'b0, 8'h00, 16'h0000);
      stim_row(REQ_COMPLETE, ERR_OK, 1'b1, 1'b0, 8'h00, 16'h0000);
      stim_row(REQ_COMPLETE, ERR_OK, 1'b1, 1'b1, 8'h00, 16'h0000);
      // crc tolerated on cid and csd
      stim_row(REQ_COMPLETE, ERR_CRC, 1'b1, 1'b1, 8'h00, 16'h0000);
      stim_row(REQ_COMPLETE, ERR_OK, 1'b1, 1'b1, 8'hFF, 16'hFFFF);
      stim_row(REQ_COMPLETE, ERR_CRC, 1'b1, 1'b1, 8'h00, 16'h0000);
      stim_row(REQ_START, ERR_OK, 1'b1, 1'b1, 8'h00, 16'h0000);
      want_last(ACT_RESET, '0, '0, RK_NONE, 1'b0, 1'b0, '0);
      // bad echo, then cmd55 refused: fall back to mmc
      stim_row(REQ_COMPLETE, ERR_OK, 1'b1, 1'b0, 8'h00, 16'h0000);
      stim_row(REQ_COMPLETE, ERR_OK, 1'b1, 1'b0, 8'h00, 16'h0000);
      stim_row(REQ_COMPLETE, ERR_OK, 1'b1, 1'b0, 8'h55, 16'h0000);
      stim_row(REQ_COMPLETE, ERR_HARD, 1'b1, 1'b0, 8'h00, 16'h0000);
      stim_row(REQ_COMPLETE, ERR_OK, 1'b1, 1'b0, 8'h00, 16'h0000);
      want_last(ACT_SEND, CMD_SEND_OP, {8'd0, HOST_OCR_RESET}, RK_R3, 1'b0, 1'b0, '0);
      stim_row(REQ_COMPLETE, ERR_OK, 1'b1, 1'b0, 8'h00, 16'h0000);
      stim_row(REQ_COMPLETE, ERR_OK, 1'b1, 1'b1, 8'h00, 16'h0000);
      stim_row(REQ_COMPLETE, ERR_OK, 1'b1, 1'b1, 8'h00, 16'h0000);
      stim_row(REQ_COMPLETE, ERR_OK, 1'b1, 1'b1, 8'h00, 16'h1234);
      // restart in the middle of the sequence
      stim_row(REQ_START, ERR_OK, 1'b1, 1'b1, 8'h00, 16'h0000);
      want_last(ACT_RESET, '0, '0, RK_NONE, 1'b0, 1'b0, '0);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_item(row.stim, row.typed, row.want);
      end

      // three back-pressure regimes, four register settings in each
      for (int regime = 0; regime < 3; regime++) begin
         req_idle_pct = (regime == 0) ? 9 : (regime == 1) ? 71 : 0;
         rsp_idle_pct = (regime == 0) ? 71 : (regime == 1) ? 9 : 0;
         for (setting = 0; setting < 4; setting++) begin
            case (setting)
               0: begin
                  ocr_value = '0;
                  rca_value = '0;
               end
               1: begin
                  // rca write carries bits above the register width
                  ocr_value = '1;
                  rca_value = '1;
               end
               2: begin
                  // nonzero window with no voltage bits in the mask
                  ocr_value = ~OCR_VOLT_MASK;
                  rca_value = {8'd0, RCA_W'($urandom)};
               end
               default: begin
                  ocr_value = OCR_W'($urandom);
                  rca_value = 24'($urandom);
               end
            endcase
            write_register(CSR_HOST_OCR, ocr_value);
            write_register(CSR_MMC_RCA, rca_value);
            repeat (RANDOM_ITEMS) send_item(next_random_item(), 1'b0, unused);
         end
      end

      // drain, then leave room for any stray answer
      req_tvalid = 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
